/* hdl/dmwc_pkg.sv */
// ----------------------------------------------------------------------------
// dmwc_pkg
// Shared widths, defaults and types of the direct-mapped write-back cache
// tag controller.
// ----------------------------------------------------------------------------
package dmwc_pkg;

  localparam int ADDR_W          = 32;
  localparam int OFF_FW          = 5;
  localparam int BLK_FW          = 27;
  localparam int IDX_FW          = 7;
  localparam int TAG_FW          = 20;
  localparam int CNT_W           = 32;
  localparam int DEF_LINES       = 128;
  localparam int DEF_OFFSET_BITS = 5;

  typedef struct packed {
    logic valid;
    logic dirty;
  } dmwc_flags_t;

  typedef struct packed {
    logic fire;
    logic hit;
    logic wback;
  } dmwc_evt_t;

  typedef struct packed {
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] transfers;
  } dmwc_totals_t;

endpackage

/* hdl/dmwc_req_if.sv */
// ----------------------------------------------------------------------------
// dmwc_req_if
// Access channel: byte address and write flag per beat.
// ----------------------------------------------------------------------------
interface dmwc_req_if;

  logic                       valid;
  logic                       ready;
  logic [dmwc_pkg::ADDR_W-1:0] address;
  logic                       is_write;

  modport source (output valid, output address, output is_write, input ready);
  modport sink   (input valid, input address, input is_write, output ready);

endinterface

/* hdl/dmwc_rsp_if.sv */
// ----------------------------------------------------------------------------
// dmwc_rsp_if
// Result channel: address split, lookup outcome and running totals per beat.
// ----------------------------------------------------------------------------
interface dmwc_rsp_if;

  logic                       valid;
  logic                       ready;
  logic [dmwc_pkg::OFF_FW-1:0] byte_offset;
  logic [dmwc_pkg::BLK_FW-1:0] block_number;
  logic [dmwc_pkg::IDX_FW-1:0] line_index;
  logic [dmwc_pkg::TAG_FW-1:0] tag_value;
  logic                       miss;
  logic                       fetch_block;
  logic                       write_back;
  logic                       replaced;
  logic [dmwc_pkg::TAG_FW-1:0] evicted_tag;
  logic [dmwc_pkg::CNT_W-1:0]  hit_total;
  logic [dmwc_pkg::CNT_W-1:0]  miss_total;
  logic [dmwc_pkg::CNT_W-1:0]  transfer_total;

  modport source (
    output valid, output byte_offset, output block_number, output line_index,
    output tag_value, output miss, output fetch_block, output write_back,
    output replaced, output evicted_tag, output hit_total, output miss_total,
    output transfer_total, input ready
  );
  modport sink (
    input valid, input byte_offset, input block_number, input line_index,
    input tag_value, input miss, input fetch_block, input write_back,
    input replaced, input evicted_tag, input hit_total, input miss_total,
    input transfer_total, output ready
  );

endinterface

/* hdl/dmwc_line_ram.sv */
// ----------------------------------------------------------------------------
// dmwc_line_ram
// Line state storage: flag memory (valid, dirty) and tag memory, one read
// and one write port each, registered read data. Sweeps the flag memory to
// zero after reset, one line per cycle.
// ----------------------------------------------------------------------------
module dmwc_line_ram #(
  parameter int LINES = dmwc_pkg::DEF_LINES,
  parameter int TAG_W = dmwc_pkg::ADDR_W - dmwc_pkg::DEF_OFFSET_BITS - $clog2(LINES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [$clog2(LINES)-1:0]   rd_idx,
  output dmwc_pkg::dmwc_flags_t      rd_flags,
  output logic [TAG_W-1:0]           rd_tag,
  input  logic                       wr_en,
  input  logic [$clog2(LINES)-1:0]   wr_idx,
  input  dmwc_pkg::dmwc_flags_t      wr_flags,
  input  logic [TAG_W-1:0]           wr_tag,
  output logic                       busy
);
  import dmwc_pkg::*;

  localparam int IDX_W = $clog2(LINES);

  dmwc_flags_t      flags_mem [LINES];
  logic [TAG_W-1:0] tag_mem   [LINES];

  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;

  logic             fl_we;
  logic [IDX_W-1:0] fl_addr;
  dmwc_flags_t      fl_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + IDX_W'(1);
      if (clr_idx_r == IDX_W'(LINES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    fl_we   = clr_busy_r || wr_en;
    fl_addr = clr_busy_r ? clr_idx_r : wr_idx;
    fl_data = clr_busy_r ? '0 : wr_flags;
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      flags_mem[fl_addr] <= fl_data;
    end
    if (rd_en) begin
      rd_flags <= flags_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_idx] <= wr_tag;
    end
    if (rd_en) begin
      rd_tag <= tag_mem[rd_idx];
    end
  end

  assign busy = clr_busy_r;

endmodule

/* hdl/dmwc_stats.sv */
// ----------------------------------------------------------------------------
// dmwc_stats
// Saturating hit, miss and transfer counters; presents the totals that
// include the access in flight.
// ----------------------------------------------------------------------------
module dmwc_stats (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dmwc_pkg::dmwc_evt_t    evt,
  output dmwc_pkg::dmwc_totals_t totals_nxt
);
  import dmwc_pkg::*;

  dmwc_totals_t tot_r;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, v} + (CNT_W+1)'(inc);
    return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

  always_comb begin
    totals_nxt.hits      = sat_add(tot_r.hits, {1'b0, evt.hit});
    totals_nxt.misses    = sat_add(tot_r.misses, {1'b0, !evt.hit});
    totals_nxt.transfers = sat_add(tot_r.transfers,
                                   2'(!evt.hit) + 2'(evt.wback));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
    end else if (evt.fire) begin
      tot_r <= totals_nxt;
    end
  end

endmodule

/* hdl/direct_mapped_writeback_cache_tags.sv */
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_tags
// Pipeline: access register (s1), then result register; throughput: one
// access per cycle unless the result channel stalls, set by the single
// read/write port pair of the line memories. Back-to-back accesses to one
// line see the previous update by forwarding. Reset: counters clear at once;
// the flag memory is swept to zero, during which no access is taken.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_tags #(
  parameter int LINES       = dmwc_pkg::DEF_LINES,
  parameter int OFFSET_BITS = dmwc_pkg::DEF_OFFSET_BITS
) (
  input logic       clk,
  input logic       rst_n,
  dmwc_req_if.sink  in_ch,
  dmwc_rsp_if.source out_ch
);
  import dmwc_pkg::*;

  localparam int IDX_W = $clog2(LINES);
  localparam int TAG_W = ADDR_W - OFFSET_BITS - IDX_W;

  logic              ram_busy;
  dmwc_flags_t       rd_flags;
  logic [TAG_W-1:0]  rd_tag;
  dmwc_flags_t       wr_flags;
  dmwc_evt_t         evt;
  dmwc_totals_t      totals_nxt;

  logic              in_ready;
  logic              in_take;
  logic [IDX_W-1:0]  in_idx;

  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_wr_r;
  logic              s1_fire;
  logic [IDX_W-1:0]  s1_idx;
  logic [TAG_W-1:0]  s1_tag;

  logic              fwd_r;
  dmwc_flags_t       fwd_flags_r;
  logic [TAG_W-1:0]  fwd_tag_r;

  dmwc_flags_t       cur_flags;
  logic [TAG_W-1:0]  cur_tag;
  logic              hit;
  logic              repl;

  logic [ADDR_W-1:0] offs_ext;
  logic [ADDR_W-1:0] blk_ext;
  logic [ADDR_W-1:0] idx_ext;
  logic [ADDR_W-1:0] tag_ext;
  logic [ADDR_W-1:0] old_ext;

  logic              out_valid_r;
  logic [OFF_FW-1:0] offs_r;
  logic [BLK_FW-1:0] blk_r;
  logic [IDX_FW-1:0] idx_r;
  logic [TAG_FW-1:0] tag_r;
  logic              miss_r;
  logic              wback_r;
  logic              repl_r;
  logic [TAG_FW-1:0] old_tag_r;
  dmwc_totals_t      tot_r;

  // access stage
  assign in_idx   = in_ch.address[OFFSET_BITS +: IDX_W];
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !ram_busy && (!s1_valid_r || s1_fire);
  assign in_take  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= s1_fire && (in_idx == s1_idx);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_addr_r   <= in_ch.address;
      s1_wr_r     <= in_ch.is_write;
      fwd_flags_r <= wr_flags;
      fwd_tag_r   <= s1_tag;
    end
  end

  // lookup and update stage
  assign s1_idx = s1_addr_r[OFFSET_BITS +: IDX_W];
  assign s1_tag = s1_addr_r[ADDR_W-1 -: TAG_W];

  always_comb begin
    cur_flags      = fwd_r ? fwd_flags_r : rd_flags;
    cur_tag        = fwd_r ? fwd_tag_r : rd_tag;
    hit            = cur_flags.valid && (cur_tag == s1_tag);
    repl           = !hit && cur_flags.valid;
    wr_flags.valid = 1'b1;
    wr_flags.dirty = s1_wr_r || (hit && cur_flags.dirty);
    evt.fire       = s1_fire;
    evt.hit        = hit;
    evt.wback      = repl && cur_flags.dirty;
    offs_ext       = ADDR_W'(s1_addr_r[OFFSET_BITS-1:0]);
    blk_ext        = s1_addr_r >> OFFSET_BITS;
    idx_ext        = ADDR_W'(s1_idx);
    tag_ext        = ADDR_W'(s1_tag);
    old_ext        = repl ? ADDR_W'(cur_tag) : '0;
  end

  dmwc_line_ram #(
    .LINES (LINES),
    .TAG_W (TAG_W)
  ) u_line_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_take),
    .rd_idx   (in_idx),
    .rd_flags (rd_flags),
    .rd_tag   (rd_tag),
    .wr_en    (s1_fire),
    .wr_idx   (s1_idx),
    .wr_flags (wr_flags),
    .wr_tag   (s1_tag),
    .busy     (ram_busy)
  );

  dmwc_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt        (evt),
    .totals_nxt (totals_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      offs_r    <= offs_ext[OFF_FW-1:0];
      blk_r     <= blk_ext[BLK_FW-1:0];
      idx_r     <= idx_ext[IDX_FW-1:0];
      tag_r     <= tag_ext[TAG_FW-1:0];
      miss_r    <= !hit;
      wback_r   <= evt.wback;
      repl_r    <= repl;
      old_tag_r <= old_ext[TAG_FW-1:0];
      tot_r     <= totals_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_offset    = offs_r;
  assign out_ch.block_number   = blk_r;
  assign out_ch.line_index     = idx_r;
  assign out_ch.tag_value      = tag_r;
  assign out_ch.miss           = miss_r;
  assign out_ch.fetch_block    = miss_r;
  assign out_ch.write_back     = wback_r;
  assign out_ch.replaced       = repl_r;
  assign out_ch.evicted_tag    = old_tag_r;
  assign out_ch.hit_total      = tot_r.hits;
  assign out_ch.miss_total     = tot_r.misses;
  assign out_ch.transfer_total = tot_r.transfers;

`ifndef SYNTHESIS
  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    ram_busy |-> !in_ch.ready)
    else $error("access taken during flag sweep");

  a_wback_needs_repl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && evt.wback |-> repl && !hit)
    else $error("write-back without eviction");

  a_repl_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.replaced |-> out_ch.miss)
    else $error("replacement reported on hit");

  a_transfers_cover_misses: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_ch.transfer_total >= out_ch.miss_total)
    else $error("transfer total below miss total");
`endif

endmodule
